@@ hw/rtl/rc4_pkg.sv @@
`default_nettype none

package rc4_pkg;

    localparam int KEY_BYTES  = 256;
    localparam int KEY_CNT_W  = 9;
    localparam int PERM_DEPTH = 256;

    typedef enum logic {
        CMD_KEY  = 1'b0,
        CMD_DATA = 1'b1
    } cmd_t;

    // Datapath step selected by the controller each cycle
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_DJ,    // data: tx back, read S[j+tx]
        STEP_DT,    // data: ty back, write S[i]=ty, read S[tx+ty]
        STEP_DO,    // data: write S[j]=tx, keystream ready
        STEP_KA,    // schedule: read S[n] and key[k], retire previous S[j]=t
        STEP_KB,    // schedule: j += key + t, read S[j]
        STEP_KC,    // schedule: write S[n]=S[j], advance n and k
        STEP_KF     // schedule: retire last S[j]=t
    } step_t;

    typedef struct packed {
        logic  start_data;
        logic  load_key;
        logic  sched_init;
        logic  out_load;
        step_t step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic n_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rc4_if.sv @@
`default_nettype none

interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output cmd, output data_byte, output last, input ready);
    modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rc4_stream_cipher.sv @@
// Data word: result registered in DO, after DJ and DT, and held there while the output
// stalls; the next word may enter in DO. The order follows the dependent read/read/write
// sequence on the one-read, one-write permutation RAM. Key word without last: input stays
// open. Key word with last: input held off for 256 schedule steps plus a final write.
// Async active-low reset: permutation reads as identity, i = j = 0, key count 0.
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rc4_in_if.sink    in_ch,
    rc4_out_if.source out_ch
);

    // Controller sequences the permutation RAM accesses; the datapath owns
    // the RAM, the key store, the indices and the output register.
    //
    // Data word flow (one RAM read + one RAM write port, write-to-read bypass):
    //   accept : read S[i+1]
    //   DJ     : j += tx, read S[j]
    //   DT     : write S[i] = ty, read S[tx+ty]
    //   DO     : write S[j] = tx, load out register; next word may enter here
    //
    // Key schedule step n:
    //   KA : read S[n] and key[k], retire S[j] = t of the previous step
    //   KB : j += key[k] + t, read S[j]
    //   KC : write S[n] = S[j]
    // A per-entry valid vector, cleared at schedule start, stands in for
    // reloading the identity permutation.

    ctrl_cmd_t  ctl;
    dp_status_t sts;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;

    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_last   (in_ch.last),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rc4_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .data_byte (in_ch.data_byte),
        .sts       (sts),
        .out_byte  (out_byte)
    );

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid;
    assign out_ch.out_byte = out_byte;

endmodule

`default_nettype wire

@@ hw/rtl/rc4_datapath.sv @@
`default_nettype none

module rc4_datapath
    import rc4_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  ctl,
    input  wire logic [7:0] data_byte,
    output dp_status_t      sts,
    output logic [7:0]      out_byte
);

    logic [7:0] perm_mem [PERM_DEPTH];
    logic [7:0] key_mem  [KEY_BYTES];
    logic [PERM_DEPTH-1:0] valid_reg;

    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] n_reg, n_next;
    logic [7:0] k_reg, k_next;
    logic [KEY_CNT_W-1:0] key_count_reg, key_count_next;

    logic [7:0] tx_reg, t_reg, byte_reg, out_byte_reg, kdata_reg;
    logic [7:0] rdata_reg, raddr_reg;
    logic       rvalid_reg;

    logic       re, we, fwd, key_wr;
    logic [7:0] raddr, waddr, wdata;
    logic [7:0] perm_rd, j_sum, ks;

    // entries never written since the last clear read as their own index
    assign perm_rd = rvalid_reg ? rdata_reg : raddr_reg;
    assign j_sum   = j_reg + kdata_reg + perm_rd;
    assign fwd     = we && (waddr == raddr);
    assign key_wr  = ctl.load_key && (key_count_reg < KEY_CNT_W'(KEY_BYTES));
    assign ks      = (t_reg == j_reg) ? tx_reg : perm_rd;

    always_comb
    begin
        re    = 1'b0;
        raddr = i_reg + 8'd1;
        we    = 1'b0;
        waddr = j_reg;
        wdata = tx_reg;
        unique case (ctl.step)
            STEP_NONE: ;
            STEP_DJ:
            begin
                re    = 1'b1;
                raddr = j_reg + perm_rd;
            end
            STEP_DT:
            begin
                re    = 1'b1;
                raddr = tx_reg + perm_rd;
                we    = 1'b1;
                waddr = i_reg;
                wdata = perm_rd;
            end
            STEP_DO:
            begin
                we = 1'b1;
            end
            STEP_KA:
            begin
                re    = 1'b1;
                raddr = n_reg;
                we    = (n_reg != 8'd0);
            end
            STEP_KB:
            begin
                re    = 1'b1;
                raddr = j_sum;
            end
            STEP_KC:
            begin
                we    = 1'b1;
                waddr = n_reg;
                wdata = perm_rd;
            end
            STEP_KF:
            begin
                we = 1'b1;
            end
        endcase
        if (ctl.start_data)
        begin
            re    = 1'b1;
            raddr = i_reg + 8'd1;
        end
    end

    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        key_count_next = key_count_reg;
        if (key_wr)
            key_count_next = key_count_reg + KEY_CNT_W'(1);
        if (ctl.start_data)
            i_next = i_reg + 8'd1;
        unique case (ctl.step)
            STEP_DJ: j_next = j_reg + perm_rd;
            STEP_KB: j_next = j_sum;
            STEP_KC:
            begin
                n_next = n_reg + 8'd1;
                if ({1'b0, k_reg} + KEY_CNT_W'(1) >= key_count_reg)
                    k_next = 8'd0;
                else
                    k_next = k_reg + 8'd1;
            end
            STEP_KF:
            begin
                j_next         = 8'd0;
                key_count_next = '0;
            end
            default: ;
        endcase
        if (ctl.sched_init)
        begin
            i_next = 8'd0;
            j_next = 8'd0;
            n_next = 8'd0;
            k_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            n_reg         <= 8'd0;
            k_reg         <= 8'd0;
            key_count_reg <= '0;
            valid_reg     <= '0;
            rvalid_reg    <= 1'b0;
            raddr_reg     <= 8'd0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            key_count_reg <= key_count_next;
            if (ctl.sched_init)
                valid_reg <= '0;
            else if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
            begin
                raddr_reg  <= raddr;
                rvalid_reg <= fwd || valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            perm_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= fwd ? wdata : perm_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (key_wr)
            key_mem[key_count_reg[7:0]] <= data_byte;
        if (ctl.step == STEP_KA)
            kdata_reg <= key_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start_data)
            byte_reg <= data_byte;
        if (ctl.step == STEP_DJ || ctl.step == STEP_KB)
            tx_reg <= perm_rd;
        if (ctl.step == STEP_DT)
        begin
            t_reg <= tx_reg + perm_rd;
        end
        if (ctl.out_load)
            out_byte_reg <= byte_reg ^ ks;
    end

    assign sts.n_last = (n_reg == 8'hFF);
    assign out_byte   = out_byte_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rc4_ctrl.sv @@
`default_nettype none

module rc4_ctrl
    import rc4_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_cmd,
    input  wire logic       in_last,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       ctl
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DJ   = 8'b0000_0010,
        ST_DT   = 8'b0000_0100,
        ST_DO   = 8'b0000_1000,
        ST_KA   = 8'b0001_0000,
        ST_KB   = 8'b0010_0000,
        ST_KC   = 8'b0100_0000,
        ST_KF   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free, accept;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DO) && out_free);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctl        = '{start_data: 1'b0, load_key: 1'b0, sched_init: 1'b0,
                       out_load: 1'b0, step: STEP_NONE};
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: ;
            ST_DJ:
            begin
                ctl.step   = STEP_DJ;
                state_next = ST_DT;
            end
            ST_DT:
            begin
                ctl.step   = STEP_DT;
                state_next = ST_DO;
            end
            ST_DO:
            begin
                ctl.step = STEP_DO;
                if (out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_KA:
            begin
                ctl.step   = STEP_KA;
                state_next = ST_KB;
            end
            ST_KB:
            begin
                ctl.step   = STEP_KB;
                state_next = ST_KC;
            end
            ST_KC:
            begin
                ctl.step   = STEP_KC;
                state_next = sts.n_last ? ST_KF : ST_KA;
            end
            ST_KF:
            begin
                ctl.step   = STEP_KF;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // new word, taken in idle or while the previous result retires
        if (accept)
        begin
            if (in_cmd == CMD_DATA)
            begin
                ctl.start_data = 1'b1;
                state_next     = ST_DJ;
            end
            else
            begin
                ctl.load_key = 1'b1;
                if (in_last)
                begin
                    ctl.sched_init = 1'b1;
                    state_next     = ST_KA;
                end
                else
                    state_next = ST_IDLE;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rc4_checker.sv @@
`default_nettype none

module rc4_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       in_cmd,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("result word changed while stalled");

    // a data word keeps the input closed through its RAM sequence
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_cmd |=> !in_ready ##1 !in_ready)
        else $error("input reopened during data word");

    // final key word starts the schedule, input stays closed
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !in_cmd && in_last |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input reopened during key schedule");

    // a new result only appears at the end of a data word sequence
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready, 2))
        else $error("result word appeared without a data sequence");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte)
);

`default_nettype wire

@@ tb/tb.sv @@
module tb;
    import rc4_pkg::*;

    localparam int ITEMS       = 1150;
    localparam int GAP_MAX     = 18;
    localparam int HOLD_CYCLES = 400;
    // A key word with last blocks the input for the whole key schedule.
    localparam int TAIL_CYCLES = 800;
    localparam int IDLE_LIMIT  = 4000;

    logic clk = 1'b0;
    logic rst_n;

    rc4_in_if  in_ch ();
    rc4_out_if out_ch ();

    rc4_stream_cipher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Cipher predictor: own copy of the permutation, key store and indices
    // ---------------------------------------------------------------
    logic [7:0] sbox [256];
    logic [7:0] key_mem [256];
    logic [8:0] key_len;
    logic [7:0] gen_i;
    logic [7:0] gen_j;

    logic [7:0] cipher_q [$];

    int errors         = 0;
    int words_sent     = 0;
    int key_words      = 0;
    int data_words     = 0;
    int schedules      = 0;
    int results_seen   = 0;
    int cycle_no       = 0;
    bit tx_burst       = 1'b0;
    bit rx_burst       = 1'b0;
    bit hold_req       = 1'b0;

    function automatic void predictor_reset();
        for (int n = 0; n < 256; n++)
        begin
            sbox[n]    = 8'(n);
            key_mem[n] = 8'h00;
        end
        key_len = '0;
        gen_i   = '0;
        gen_j   = '0;
    endfunction

    function automatic void run_key_schedule();
        int         len;
        int         k;
        logic [7:0] j;
        logic [7:0] t;
        len = (key_len == 0) ? 1 : int'(key_len);
        k   = 0;
        j   = '0;
        gen_i = '0;
        gen_j = '0;
        for (int n = 0; n < 256; n++)
            sbox[n] = 8'(n);
        for (int n = 0; n < 256; n++)
        begin
            t       = sbox[n];
            j       = j + key_mem[k] + t;
            sbox[n] = sbox[j];
            sbox[j] = t;
            k++;
            if (k >= len)
                k = 0;
        end
        key_len = '0;
        schedules++;
    endfunction

    // Advance the predictor by one accepted word; data words queue a cipher byte.
    function automatic void predict_word(input cmd_t cmd, input logic [7:0] b, input logic last);
        logic [7:0] tx;
        logic [7:0] ty;
        logic [7:0] ks_idx;
        if (cmd == CMD_KEY)
        begin
            key_words++;
            if (key_len < KEY_BYTES)
            begin
                key_mem[key_len[7:0]] = b;
                key_len = key_len + 9'd1;
            end
            if (last)
                run_key_schedule();
        end
        else
        begin
            data_words++;
            gen_i        = gen_i + 8'd1;
            tx           = sbox[gen_i];
            gen_j        = gen_j + tx;
            ty           = sbox[gen_j];
            sbox[gen_i]  = ty;
            sbox[gen_j]  = tx;
            ks_idx       = tx + ty;
            cipher_q.push_back(sbox[ks_idx] ^ b);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH cycle %0d: %s", cycle_no, msg);
    endtask

    // ---------------------------------------------------------------
    // Sender: offer one word, wait for it to be taken, then idle a drawn gap.
    // Valid stays high across back-to-back words.
    // ---------------------------------------------------------------
    task automatic send_word(input cmd_t cmd, input logic [7:0] b, input logic last);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.data_byte <= b;
        in_ch.last      <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_word(cmd, b, last);
        words_sent++;
        gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (cipher_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_key(input int len);
        for (int k = 0; k < len; k++)
            send_word(CMD_KEY, 8'($urandom), k == len - 1);
    endtask

    task automatic send_data(input int count);
        for (int n = 0; n < count; n++)
            send_word(CMD_DATA, 8'($urandom), 1'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Receiver and result check, one pass per clock
    // ---------------------------------------------------------------
    initial
    begin
        int         stall_left;
        int         hold_left;
        logic [7:0] want;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (cipher_q.size() == 0)
                    report_mismatch($sformatf("result %02h with nothing expected",
                                              out_ch.out_byte));
                else
                begin
                    want = cipher_q.pop_front();
                    if (out_ch.out_byte !== want)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_ch.out_byte, want));
                end
                stall_left = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog: cycles in which no word moves on either side
    always @(posedge clk)
    begin
        static int idle_cycles = 0;
        cycle_no++;
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles with no word moving, %0d results pending",
                         idle_cycles, cipher_q.size());
                $display("tb failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Generator straight out of reset runs on the identity permutation.
    task automatic test_reset_state();
        send_word(CMD_DATA, 8'h00, 1'b0);
        send_word(CMD_DATA, 8'hFF, 1'b0);
        send_word(CMD_DATA, 8'hA5, 1'b1);   // last ignored on data
        send_word(CMD_DATA, 8'h5A, 1'b0);
    endtask

    task automatic test_short_keys();
        send_word(CMD_KEY, 8'hFF, 1'b1);    // one-byte key
        send_word(CMD_DATA, 8'h00, 1'b0);
        send_word(CMD_DATA, 8'hFF, 1'b1);
        send_word(CMD_KEY, 8'h00, 1'b0);
        send_word(CMD_KEY, 8'h80, 1'b0);
        send_word(CMD_KEY, 8'h7F, 1'b1);
        send_word(CMD_DATA, 8'h01, 1'b0);
        send_word(CMD_DATA, 8'hFE, 1'b0);
    endtask

    // Data words while a key is half loaded use the old permutation.
    task automatic test_data_mid_key();
        send_word(CMD_KEY, 8'h12, 1'b0);
        send_word(CMD_KEY, 8'h34, 1'b0);
        send_word(CMD_DATA, 8'hC3, 1'b0);
        send_word(CMD_DATA, 8'h3C, 1'b1);
        send_word(CMD_DATA, 8'hFF, 1'b0);
        send_word(CMD_KEY, 8'h56, 1'b1);
        send_word(CMD_DATA, 8'h00, 1'b0);
        send_word(CMD_DATA, 8'h99, 1'b0);
    endtask

    // Fill the key store, overflow it, then end the key with a dropped byte.
    task automatic test_full_key_store();
        bit burst_save;
        burst_save = tx_burst;
        tx_burst   = 1'b1;
        for (int k = 0; k < KEY_BYTES + 3; k++)
            send_word(CMD_KEY, 8'($urandom), 1'b0);
        tx_burst = burst_save;
        send_word(CMD_KEY, 8'($urandom), 1'b1);
        send_data(8);
    endtask

    // Receiver holds off while the sender keeps pushing.
    task automatic test_backpressure();
        bit burst_save;
        wait_for_results();
        burst_save = tx_burst;
        tx_burst   = 1'b1;
        hold_req   = 1'b1;
        send_data(60);
        tx_burst = burst_save;
    endtask

    task automatic test_sender_pause();
        send_key(5);
        send_data(20);
        wait_for_results();
        send_data(20);
    endtask

    // Mostly keyed sessions with random content; some noise and stray key bytes.
    task automatic test_random();
        int klen;
        int ndata;
        while (words_sent < ITEMS)
        begin
            tx_burst = ($urandom_range(0, 4) == 0);
            rx_burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                for (int n = 0; n < 10; n++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_word(CMD_KEY, 8'($urandom), $urandom_range(0, 7) == 0);
                    else
                        send_word(CMD_DATA, 8'($urandom), 1'($urandom));
                end
            end
            else
            begin
                klen = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 270)
                                                    : $urandom_range(1, 16);
                send_key(klen);
                ndata = $urandom_range(10, 60);
                for (int n = 0; n < ndata; n++)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_word(CMD_KEY, 8'($urandom), 1'b0);
                    else
                        send_word(CMD_DATA, 8'($urandom), 1'($urandom));
                end
            end
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial
    begin
        predictor_reset();
        rst_n = 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_KEY;
        in_ch.data_byte <= 8'h00;
        in_ch.last      <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_short_keys();
        test_data_mid_key();
        test_full_key_store();
        test_backpressure();
        test_sender_pause();
        test_random();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d key words, %0d data words, %0d key schedules, %0d results",
                 key_words, data_words, schedules, results_seen);
        $display("with random gaps both ways, a %0d-cycle output hold-off and a full key store",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
